// ----- rtl/stq_pkg.sv -----
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants for the sorted timer queue
// holds command codes, status codes and default sizes
// ----------------------------------------------------------------------------
`default_nettype none

package stq_pkg;

  // default table size and id width
  localparam int unsigned TableDepthDef = 32;
  localparam int unsigned IdBitsDef     = 16;

  // fixed field widths
  localparam int unsigned IntervalW = 32;
  localparam int unsigned TimeW     = 48;
  localparam int unsigned WaitW     = 49;
  localparam int unsigned TolW      = 16;
  localparam int unsigned IdPortW   = 16;

  localparam logic [TolW-1:0] TolReset = 16'd10;

  // request codes
  typedef enum logic [1:0] {
    CMD_ADD_PER  = 2'd0,
    CMD_ADD_ONE  = 2'd1,
    CMD_CANCEL   = 2'd2,
    CMD_CHECK    = 2'd3
  } cmd_e;

  // status codes
  localparam logic [1:0] StNew      = 2'd0;
  localparam logic [1:0] StReplaced = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;
  localparam logic [1:0] StRemoved  = 2'd0;
  localparam logic [1:0] StAbsent   = 2'd1;
  localparam logic [1:0] StFired    = 2'd0;
  localparam logic [1:0] StWaiting  = 2'd1;
  localparam logic [1:0] StEmpty    = 2'd2;

  // saturating 48-bit time add
  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [IntervalW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {{(TimeW + 1 - IntervalW){1'b0}}, b};
    return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/stq_mem.sv -----
// ----------------------------------------------------------------------------
// stq_mem: timer slot storage
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module stq_mem #(
  parameter int unsigned Depth = 32,
  parameter int unsigned Width = 97
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/sorted_timer_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_timer_queue: table of one-shot and periodic timers sorted by expiry
// sequencer walks a slot memory to find, drop and insert entries
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid_i, in_stall_o, cmd_i .. keep_i   | request in
//  out     | out_valid_o, out_stall_i, status_o ..     | result out
//  cfg     | cfg_we_i, cfg_wdata_i                     | tolerance write
//
//  from acceptance to result, a request passes through the id scan, the
//  shift-down, the insert scan and the shift-up as needed; each moves
//  one slot a cycle through the single read and single write port of the
//  slot memory; the next request is taken in the idle state that follows
//  reset clears the fill count, so the table is empty at once
//  the result waits in an output register while out_stall_i is high; a new
//  request may start meanwhile but cannot finish until that result leaves
`default_nettype none

module sorted_timer_queue #(
  parameter int unsigned TABLE_DEPTH = stq_pkg::TableDepthDef,
  parameter int unsigned ID_BITS     = stq_pkg::IdBitsDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [stq_pkg::TolW-1:0]          cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [1:0]                        cmd_i,
  input  wire logic [stq_pkg::IdPortW-1:0]       timer_id_i,
  input  wire logic [stq_pkg::IntervalW-1:0]     interval_ms_i,
  input  wire logic [stq_pkg::TimeW-1:0]         now_ms_i,
  input  wire logic                              keep_repeat_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [1:0]                             status_o,
  output logic [stq_pkg::IdPortW-1:0]            fired_id_o,
  output logic [stq_pkg::IntervalW-1:0]          fired_interval_o,
  output logic signed [stq_pkg::WaitW-1:0]       wait_ms_o
);

  import stq_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW = ID_BITS + IntervalW + TimeW + 1;
  localparam int unsigned KB = (ID_BITS < IdPortW) ? ID_BITS : IdPortW;
  localparam int unsigned ExpLo = 1;
  localparam int unsigned IntLo = 1 + TimeW;
  localparam int unsigned IdLo  = 1 + TimeW + IntervalW;

  typedef enum logic [2:0] {
    S_IDLE, S_FIND, S_DROP, S_SCAN, S_SHIFT, S_CHECK, S_DONE
  } state_e;

  state_e state_q;
  logic [CW-1:0] count_q, idx_q, pos_q;
  logic [TolW-1:0] tol_q;
  cmd_e cmd_q;
  logic [ID_BITS-1:0] id_q;
  logic [IntervalW-1:0] int_q;
  logic [TimeW-1:0] now_q, nexp_q;
  logic keep_q, per_q;
  logic [1:0] res_st_q;
  logic [IdPortW-1:0] res_id_q;
  logic [IntervalW-1:0] res_int_q;
  logic [WaitW-1:0] res_wait_q;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic [ID_BITS-1:0] r_id;
  logic [IntervalW-1:0] r_int;
  logic [TimeW-1:0] r_exp;
  logic [TimeW-1:0] rearm;

  assign r_id  = rdata[EW-1:IdLo];
  assign r_int = rdata[IdLo-1:IntLo];
  assign r_exp = rdata[IntLo-1:ExpLo];
  assign rearm = (nexp_q < now_q) ? sat_add(now_q, int_q) : nexp_q;

  stq_mem #(.Depth(TABLE_DEPTH), .Width(EW)) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = AW'(idx_q);
    wdata = rdata;
    raddr = AW'(idx_q + CW'(1));
    unique case (state_q)
      S_IDLE: raddr = '0;
      S_FIND: begin
        if (idx_q == count_q) begin
          raddr = '0;
        end else begin
          raddr = AW'(idx_q + CW'(1));
        end
      end
      S_CHECK: raddr = AW'(idx_q + CW'(1));
      S_DROP: begin
        raddr = AW'(idx_q + CW'(1));
        if (idx_q != count_q) begin
          we    = 1'b1;
          waddr = AW'(idx_q - CW'(1));
        end else begin
          raddr = '0;
        end
      end
      S_SCAN: begin
        if (idx_q == count_q || r_exp > nexp_q) begin
          raddr = AW'(count_q - CW'(1));
        end
      end
      S_SHIFT: begin
        raddr = AW'(idx_q - CW'(2));
        we    = 1'b1;
        waddr = AW'(idx_q);
        if (idx_q == pos_q) begin
          wdata = {id_q, int_q, nexp_q, per_q};
        end
      end
      S_DONE: raddr = '0;
      default: raddr = '0;
    endcase
  end

  // in channel
  assign in_stall_o = (state_q != S_IDLE);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      tol_q       <= TolReset;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
      // result valid: raised when a finished request can move out
      if (state_q == S_DONE && (!out_valid_o || !out_stall_i)) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q      <= cmd_e'(cmd_i);
            id_q       <= ID_BITS'(timer_id_i[KB-1:0]);
            int_q      <= interval_ms_i;
            now_q      <= now_ms_i;
            keep_q     <= keep_repeat_i;
            per_q      <= (cmd_e'(cmd_i) == CMD_ADD_PER);
            nexp_q     <= sat_add(now_ms_i, interval_ms_i);
            idx_q      <= '0;
            res_id_q   <= '0;
            res_int_q  <= '0;
            res_wait_q <= '0;
            state_q    <= (cmd_e'(cmd_i) == CMD_CHECK) ? S_CHECK : S_FIND;
          end
        end
        S_FIND: begin
          if (idx_q == count_q) begin
            // id not present
            if (cmd_q == CMD_CANCEL) begin
              res_st_q <= StAbsent;
              state_q  <= S_DONE;
            end else if (count_q == CW'(TABLE_DEPTH)) begin
              res_st_q <= StFull;
              state_q  <= S_DONE;
            end else begin
              res_st_q <= StNew;
              idx_q    <= '0;
              state_q  <= S_SCAN;
            end
          end else if (r_id == id_q) begin
            idx_q   <= idx_q + CW'(1);
            state_q <= S_DROP;
          end else begin
            idx_q <= idx_q + CW'(1);
          end
        end
        S_DROP: begin
          if (idx_q == count_q) begin
            count_q <= count_q - CW'(1);
            idx_q   <= '0;
            priority if (cmd_q == CMD_CANCEL) begin
              res_st_q <= StRemoved;
              state_q  <= S_DONE;
            end else if (cmd_q == CMD_CHECK) begin
              res_st_q <= StFired;
              nexp_q   <= rearm;
              state_q  <= (keep_q && per_q) ? S_SCAN : S_DONE;
            end else begin
              res_st_q <= StReplaced;
              state_q  <= S_SCAN;
            end
          end else begin
            idx_q <= idx_q + CW'(1);
          end
        end
        S_SCAN: begin
          if (idx_q == count_q || r_exp > nexp_q) begin
            pos_q   <= idx_q;
            idx_q   <= count_q;
            state_q <= S_SHIFT;
          end else begin
            idx_q <= idx_q + CW'(1);
          end
        end
        S_SHIFT: begin
          if (idx_q == pos_q) begin
            count_q <= count_q + CW'(1);
            state_q <= S_DONE;
          end else begin
            idx_q <= idx_q - CW'(1);
          end
        end
        S_CHECK: begin
          if (count_q == '0) begin
            res_st_q   <= StEmpty;
            res_wait_q <= {WaitW{1'b1}};
            state_q    <= S_DONE;
          end else if ({1'b0, r_exp} <= ({1'b0, now_q} + WaitW'(tol_q))) begin
            // due: pop head and keep its fields for re-arm
            id_q      <= r_id;
            int_q     <= r_int;
            per_q     <= rdata[0];
            nexp_q    <= sat_add(r_exp, r_int);
            res_id_q  <= IdPortW'(r_id);
            res_int_q <= r_int;
            idx_q     <= CW'(1);
            state_q   <= S_DROP;
          end else begin
            res_st_q   <= StWaiting;
            res_wait_q <= {1'b0, r_exp} - {1'b0, now_q};
            state_q    <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_o || !out_stall_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && (!out_valid_o || !out_stall_i)) begin
      status_o         <= res_st_q;
      fired_id_o       <= res_id_q;
      fired_interval_o <= res_int_q;
      wait_ms_o        <= res_wait_q;
    end
  end

`ifndef SYNTHESIS
  // fill count never passes the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("timer count overflow");

  // an accepted request keeps the input stalled on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request not held off");

  // the count only moves at the end of a drop or an insert
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> ($past(state_q) == S_DROP
                                     || $past(state_q) == S_SHIFT))
    else $error("count changed outside drop or insert");
`endif

endmodule

`default_nettype wire
